@@ hw/rtl/lspmd_pkg.sv @@
`timescale 1ns / 1ps

package lspmd_pkg;

  // Field widths
  localparam int unsigned POS_W    = 10;
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned SUPPLY_W = 16;
  localparam int unsigned VOLT_W   = 24;
  localparam int unsigned DB_W     = 4;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned LOSS_W   = 2;

  // Divider for set_voltage / supply, and the ratio width it leaves
  localparam int unsigned DIV_W    = VOLT_W;
  localparam int unsigned DSR_W    = SUPPLY_W;
  localparam int unsigned RATIO_W  = 7;
  localparam int unsigned PROD_W   = DUTY_W + RATIO_W;

  // Division of the product by 100: floor(x / 100) equals (x * ceil(2^30 / 100)) >> 30
  // for every x below 2^23, and the quotient stays below 2^17
  localparam int unsigned QUOT_W      = 17;
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_VOLTAGE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DUTY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_POS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 2'd3;

  // Configuration reset values
  localparam logic [VOLT_W-1:0] SET_VOLTAGE_RST  = 24'd240000;
  localparam logic [DUTY_W-1:0] DEFAULT_DUTY_RST = 16'd100;
  localparam logic [POS_W-1:0]  UPPER_POS_RST    = 10'd399;
  localparam logic [DB_W-1:0]   DEADBAND_RST     = 4'd3;

  // Command modes
  localparam logic [MODE_W-1:0] MODE_SEEK = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DOWN = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UP   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_IDLE = 3'd3;

  // Request kinds
  localparam logic FUNC_CMD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Compensation scaling and rounding
  localparam logic [DSR_W-1:0]  SCALE_DIV    = 16'd100;
  localparam logic [DSR_W-1:0]  ROUND_HALF   = 16'd50;
  localparam logic [LOSS_W-1:0] LOSS_MAX     = 2'd3;
  localparam logic [DUTY_W-1:0] DUTY_MAX     = 16'hFFFF;

  typedef struct packed {
    logic                func;
    logic [MODE_W-1:0]   mode;
    logic [POS_W-1:0]    target_position;
    logic [POS_W-1:0]    current_position;
    logic                up_limit_hit;
    logic                down_limit_hit;
    logic                link_ok;
    logic                driver_fault;
    logic [SUPPLY_W-1:0] supply_sample;
  } lspmd_req_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              direction_down;
    logic              done_res;
    logic              position_override_valid;
    logic [POS_W-1:0]  position_override_value;
    logic              driver_reset_pulse;
  } lspmd_res_t;

  typedef struct packed {
    logic accept;
    logic start_div1;
    logic load_prod;
    logic load_quot;
    logic load_out;
  } lspmd_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } lspmd_sts_t;

endpackage

@@ hw/rtl/limit_switch_position_motor_drive.sv @@
`timescale 1ns / 1ps

// Position motor drive with limit switches.
// Input channel (in_valid / in_stall / in_req): one request per command or 10 ms tick.
//   A request is taken at a clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall / out_res): exactly one result per request,
//   taken at an edge with out_valid high and out_stall low. The result sits in an
//   output register, so the block takes its next request while that result waits.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is always
//   high; write only while the block is idle.
// Sequencing: a tick, or a command that leaves the motor unpowered or uses the
//   uncompensated duty, passes from acceptance through the decide state to the
//   output register. A command that needs supply compensation also runs a restoring
//   division (set_voltage / supply), a 16x7 multiply and a reciprocal multiply for
//   the division by 100 before its result is loaded. A new request is taken only
//   once the result of the last one is in the output register.
// Reset (rst, synchronous, active high) restores the register defaults, clears the
//   loss watchdog, duty and direction, and empties the output register.
// While out_stall is high the result holds; a finished next result waits inside
//   and in_stall stays high until the output register frees.
module limit_switch_position_motor_drive (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lspmd_pkg::lspmd_req_t           in_req,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lspmd_pkg::lspmd_res_t           out_res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lspmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lspmd_pkg::VOLT_W-1:0]    cfg_data
);
  import lspmd_pkg::*;

  lspmd_cmd_t cmd;
  lspmd_sts_t sts;
  logic       cfg_wr;

  // Configuration writes never wait
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  // Sequencer: accept, decide, optional compensation steps, hand over the result
  lspmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Registers, direction and power decision, divider, multipliers and output register
  lspmd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

@@ hw/rtl/lspmd_div.sv @@
`timescale 1ns / 1ps

module lspmd_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lspmd_pkg::DIV_W-1:0] dividend,
  input  logic [lspmd_pkg::DSR_W-1:0] divisor,
  output logic                      done,
  output logic [lspmd_pkg::DIV_W-1:0] quotient
);
  import lspmd_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DIV_W-1:0] dvd;
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   rem_diff;
  logic             ge;
  logic [DSR_W-1:0] rem_next;

  // One restoring step per cycle: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem, dvd[DIV_W-1]};
    rem_diff = rem_sh - {1'b0, dsr};
    ge       = (rem_sh >= {1'b0, dsr});
    rem_next = ge ? rem_diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[DIV_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient = dvd;

endmodule

@@ hw/rtl/lspmd_dp.sv @@
`timescale 1ns / 1ps

module lspmd_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  lspmd_pkg::lspmd_cmd_t           cmd,
  output lspmd_pkg::lspmd_sts_t           sts,
  input  lspmd_pkg::lspmd_req_t           in_req,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lspmd_pkg::lspmd_res_t           out_res,
  input  logic                            cfg_wr,
  input  logic [lspmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lspmd_pkg::VOLT_W-1:0]    cfg_data
);
  import lspmd_pkg::*;

  // Configuration
  logic [VOLT_W-1:0] set_voltage;
  logic [DUTY_W-1:0] default_duty;
  logic [POS_W-1:0]  upper_pos;
  logic [DB_W-1:0]   deadband;

  // Block state
  logic [LOSS_W-1:0] loss_count;
  logic [DUTY_W-1:0] duty_reg;
  logic              dir_reg;

  // Held request, compensation product and its quotient by 100
  lspmd_req_t        req_q;
  logic [PROD_W-1:0] prod_q;
  logic [QUOT_W-1:0] quot_q;

  // Divider
  logic              div_done;
  logic [DIV_W-1:0]  div_quot;

  // Division by 100
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  logic [PROD_W-1:0]         quot_x100;
  logic [PROD_W-1:0]         rem_100;
  logic                      round_up;

  // Decision
  logic [POS_W:0]    cur_plus_db;
  logic [POS_W:0]    tgt_plus_db;
  logic              want_up;
  logic              want_down;
  logic              done_cmd;
  logic              up_block;
  logic              down_block;
  logic              power;
  logic              powered;
  logic              tick;
  logic [VOLT_W-1:0] supply_x100;
  logic              low_supply;
  logic [QUOT_W:0]   q_round;
  logic [DUTY_W-1:0] comp_duty;
  logic [DUTY_W-1:0] duty_cmd;
  logic [LOSS_W-1:0] loss_next;
  logic [DUTY_W-1:0] duty_next;
  logic              dir_next;
  lspmd_res_t        res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_voltage  <= SET_VOLTAGE_RST;
      default_duty <= DEFAULT_DUTY_RST;
      upper_pos    <= UPPER_POS_RST;
      deadband     <= DEADBAND_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_SET_VOLTAGE:  set_voltage  <= cfg_data;
        CFG_DEFAULT_DUTY: default_duty <= cfg_data[DUTY_W-1:0];
        CFG_UPPER_POS:    upper_pos    <= cfg_data[POS_W-1:0];
        CFG_DEADBAND:     deadband     <= cfg_data[DB_W-1:0];
      endcase
    end
  end

  // Product / 100 by reciprocal multiplication
  assign recip_prod = {{RECIP_W{1'b0}}, prod_q} * {{PROD_W{1'b0}}, RECIP_100};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= in_req;
    end
    if (cmd.load_prod) begin
      prod_q <= PROD_W'({{(PROD_W-DUTY_W){1'b0}}, default_duty} *
                        {{(PROD_W-RATIO_W){1'b0}}, div_quot[RATIO_W-1:0]});
    end
    if (cmd.load_quot) begin
      quot_q <= recip_prod[RECIP_SHIFT +: QUOT_W];
    end
  end

  // set_voltage / supply
  lspmd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div1),
    .dividend (set_voltage),
    .divisor  (req_q.supply_sample),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    tick        = (req_q.func == FUNC_TICK);
    cur_plus_db = {1'b0, req_q.current_position} + {{(POS_W+1-DB_W){1'b0}}, deadband};
    tgt_plus_db = {1'b0, req_q.target_position} + {{(POS_W+1-DB_W){1'b0}}, deadband};
    want_up   = 1'b0;
    want_down = 1'b0;
    done_cmd  = 1'b0;
    if (!req_q.link_ok) begin
      done_cmd = 1'b1;
    end else begin
      unique case (req_q.mode)
        MODE_SEEK: begin
          if ({1'b0, req_q.target_position} > cur_plus_db) begin
            want_up = 1'b1;
          end else if (tgt_plus_db < {1'b0, req_q.current_position}) begin
            want_down = 1'b1;
          end else begin
            done_cmd = 1'b1;
          end
        end
        MODE_DOWN: want_down = 1'b1;
        MODE_UP:   want_up   = 1'b1;
        MODE_IDLE: done_cmd  = 1'b1;
        default:   ;
      endcase
    end
    up_block   = want_up & req_q.up_limit_hit;
    down_block = want_down & req_q.down_limit_hit;
    power      = (want_up & ~req_q.up_limit_hit) | (want_down & ~req_q.down_limit_hit);
    powered    = ~tick & power & (default_duty != '0);

    // supply * 100 <= set_voltage is the same test as supply <= set_voltage / 100
    supply_x100 = ({{(VOLT_W-SUPPLY_W){1'b0}}, req_q.supply_sample} << 6)
                + ({{(VOLT_W-SUPPLY_W){1'b0}}, req_q.supply_sample} << 5)
                + ({{(VOLT_W-SUPPLY_W){1'b0}}, req_q.supply_sample} << 2);
    low_supply  = (supply_x100 <= set_voltage);

    // Remainder of the division by 100, then round up above one half
    quot_x100 = ({{(PROD_W-QUOT_W){1'b0}}, quot_q} << 6)
              + ({{(PROD_W-QUOT_W){1'b0}}, quot_q} << 5)
              + ({{(PROD_W-QUOT_W){1'b0}}, quot_q} << 2);
    rem_100   = prod_q - quot_x100;
    round_up  = (rem_100 > {{(PROD_W-DSR_W){1'b0}}, ROUND_HALF});
    q_round   = {1'b0, quot_q} + {{QUOT_W{1'b0}}, round_up};
    comp_duty = (q_round > {{(QUOT_W+1-DUTY_W){1'b0}}, DUTY_MAX}) ? DUTY_MAX
                                                                   : q_round[DUTY_W-1:0];
    duty_cmd  = !powered ? '0 : (low_supply ? default_duty : comp_duty);

    loss_next = !tick ? '0 : ((loss_count == LOSS_MAX) ? LOSS_MAX : loss_count + 1'b1);
    duty_next = tick ? ((loss_next == LOSS_MAX) ? '0 : duty_reg) : duty_cmd;
    dir_next  = (!tick && power) ? want_down : dir_reg;

    res_next.duty                    = duty_next;
    res_next.direction_down          = dir_next;
    res_next.done_res                = ~tick & (done_cmd | up_block | down_block);
    res_next.position_override_valid = ~tick & (up_block | down_block);
    res_next.position_override_value = (!tick && up_block) ? upper_pos : '0;
    res_next.driver_reset_pulse      = powered & req_q.driver_fault;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_count <= '0;
      duty_reg   <= '0;
      dir_reg    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        loss_count <= loss_next;
        duty_reg   <= duty_next;
        dir_reg    <= dir_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_res <= res_next;
    end
  end

  assign sts.need_div = powered & ~low_supply;
  assign sts.div_done = div_done;
  assign sts.out_free = ~out_valid | ~out_stall;

endmodule

@@ hw/rtl/lspmd_ctrl.sv @@
`timescale 1ns / 1ps

module lspmd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lspmd_pkg::lspmd_sts_t sts,
  output lspmd_pkg::lspmd_cmd_t cmd
);
  import lspmd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_DIV1   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.need_div) begin
          cmd.start_div1 = 1'b1;
          state_next     = S_DIV1;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.load_prod = 1'b1;
          state_next    = S_MUL;
        end
      end
      S_MUL: begin
        // Take the product / 100 quotient
        cmd.load_quot = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        // Hold until the output register can take the result
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

@@ hw/rtl/lspmd_chk.sv @@
`timescale 1ns / 1ps

module lspmd_chk (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input lspmd_pkg::lspmd_res_t out_res
);
  import lspmd_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("stalled result changed");

  // An accepted request keeps the input closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a request");

  // A limit override always stops the motor and finishes the command
  a_override_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.position_override_valid |->
      out_res.done_res && (out_res.duty == '0))
    else $error("override with motor powered");

  // No override means a zero override value
  a_override_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.position_override_valid |->
      (out_res.position_override_value == '0))
    else $error("override value without override");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind limit_switch_position_motor_drive lspmd_chk u_lspmd_chk (.*);
